@@ rtl/core/att_pkg.sv @@
// Shared types and constants for the allocation tracking table.
// Holds the request, result and table entry structs, status and command codes,
// the controller state type and a saturating counter helper. No dependencies.
`timescale 1ns / 1ps

package att_pkg;

	localparam int PTR_W  = 32;
	localparam int SIZE_W = 32;
	localparam int CTR_W  = 32;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status codes reported with every result.
	localparam logic [2:0] ST_RECORDED  = 3'd0;
	localparam logic [2:0] ST_POOL_FULL = 3'd1;
	localparam logic [2:0] ST_FREED     = 3'd2;
	localparam logic [2:0] ST_UNTRACKED = 3'd3;
	localparam logic [2:0] ST_IGNORED   = 3'd4;

	// Saturation limits of the narrow result fields.
	localparam logic [6:0]  CNT7_MAX    = 7'h7F;
	localparam logic [37:0] BYTES38_MAX = 38'h3F_FFFF_FFFF;

	typedef struct packed {
		logic              command;
		logic [PTR_W-1:0]  pointer;
		logic [SIZE_W-1:0] byte_size;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [5:0]       slot;
		logic [6:0]       match_count;
		logic [6:0]       active_count;
		logic [37:0]      active_bytes;
		logic [CTR_W-1:0] alloc_total;
		logic [CTR_W-1:0] free_total;
		logic [CTR_W-1:0] invalid_free_total;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [PTR_W-1:0]  pointer;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REPORT
	} state_t;

	// Adds two counter values and sticks at the all-ones maximum.
	function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] a,
			input logic [CTR_W-1:0] b);
		logic [CTR_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CTR_W] ? {CTR_W{1'b1}} : sum[CTR_W-1:0];
	endfunction

endpackage

@@ rtl/core/att_cell.sv @@
// One table cell of the allocation tracking ring: a valid mark, pointer and size.
// On every shift it loads the entry of its neighbor. Depends on att_pkg.
`timescale 1ns / 1ps

module att_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  att_pkg::entry_t nxt,
	output att_pkg::entry_t entry
);

	logic                       valid_q;
	logic [att_pkg::PTR_W-1:0]  pointer_q;
	logic [att_pkg::SIZE_W-1:0] size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt.valid;
		end
	end

	// Pointer and size mean nothing while the entry is not valid.
	always_ff @(posedge clk) begin
		if (shift) begin
			pointer_q <= nxt.pointer;
			size_q    <= nxt.size;
		end
	end

	assign entry.valid   = valid_q;
	assign entry.pointer = pointer_q;
	assign entry.size    = size_q;

endmodule

@@ rtl/core/att_ctrl.sv @@
// Scan controller of the allocation tracking table: sequencer, per-request
// scan state, running totals and the result register. Depends on att_pkg.
`timescale 1ns / 1ps

module att_ctrl #(
	parameter int RECORDS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  att_pkg::req_t   req,
	input  att_pkg::entry_t head,
	output att_pkg::entry_t tail,
	output logic            shift,
	output logic            done,
	output att_pkg::rsp_t   rsp
);

	localparam int IDX_W    = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int CNT_W    = $clog2(RECORDS + 1);
	localparam int BYTES_W  = att_pkg::SIZE_W + CNT_W;
	localparam int CNT_XW   = (CNT_W > 7) ? CNT_W : 7;
	localparam int BYTES_XW = (BYTES_W > 38) ? BYTES_W : 38;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORDS - 1);

	att_pkg::state_t state_q, state_n;

	att_pkg::req_t               req_q;
	logic                        null_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        placed_q;
	logic                        found_q;
	logic [IDX_W-1:0]            slot_q;
	logic [CNT_W-1:0]            match_q;
	logic [BYTES_W-1:0]          freed_q;

	logic [CNT_W-1:0]            live_cnt_q, live_cnt_n;
	logic [BYTES_W-1:0]          live_bytes_q, live_bytes_n;
	logic [att_pkg::CTR_W-1:0]   allocs_q, allocs_n;
	logic [att_pkg::CTR_W-1:0]   frees_q, frees_n;
	logic [att_pkg::CTR_W-1:0]   bad_q, bad_n;

	att_pkg::rsp_t               rsp_q, rsp_n;
	logic                        done_q;

	logic accept;
	logic is_free;
	logic take_alloc;
	logic hit_free;

	logic [CNT_XW-1:0]   match_x;
	logic [CNT_XW-1:0]   active_x;
	logic [BYTES_XW-1:0] bytes_x;
	logic [IDX_W+5:0]    slot_x;

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			att_pkg::S_IDLE: begin
				if (start) begin
					state_n = (req.pointer == '0) ? att_pkg::S_REPORT : att_pkg::S_SCAN;
				end
			end
			att_pkg::S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_n = att_pkg::S_REPORT;
				end
			end
			att_pkg::S_REPORT: begin
				state_n = att_pkg::S_IDLE;
			end
			default: begin
				state_n = att_pkg::S_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		busy  = 1'b1;
		shift = 1'b0;
		case (state_q)
			att_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			att_pkg::S_SCAN: begin
				shift = 1'b1;
			end
			att_pkg::S_REPORT: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= att_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Cell-level decision on the entry at the head of the ring.
	assign is_free    = (req_q.command == att_pkg::CMD_FREE);
	assign take_alloc = !is_free && !placed_q && !head.valid;
	assign hit_free   = is_free && head.valid && (head.pointer == req_q.pointer);

	always_comb begin
		tail = head;
		if (take_alloc) begin
			tail.valid   = 1'b1;
			tail.pointer = req_q.pointer;
			tail.size    = req_q.byte_size;
		end else if (hit_free) begin
			tail.valid = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_q   <= 1'b0;
			idx_q    <= '0;
			placed_q <= 1'b0;
			found_q  <= 1'b0;
			slot_q   <= '0;
			match_q  <= '0;
			freed_q  <= '0;
		end else if (accept) begin
			null_q   <= (req.pointer == '0);
			idx_q    <= '0;
			placed_q <= 1'b0;
			found_q  <= 1'b0;
			slot_q   <= '0;
			match_q  <= '0;
			freed_q  <= '0;
		end else if (shift) begin
			idx_q <= idx_q + 1'b1;
			if (take_alloc) begin
				placed_q <= 1'b1;
				slot_q   <= idx_q;
			end
			if (hit_free) begin
				found_q <= 1'b1;
				if (!found_q) begin
					slot_q <= idx_q;
				end
				match_q <= match_q + 1'b1;
				freed_q <= freed_q + BYTES_W'(head.size);
			end
		end
	end

	// Running totals after this request.
	always_comb begin
		live_cnt_n   = live_cnt_q;
		live_bytes_n = live_bytes_q;
		allocs_n     = allocs_q;
		frees_n      = frees_q;
		bad_n        = bad_q;
		if (!null_q) begin
			if (placed_q) begin
				live_cnt_n   = live_cnt_q + 1'b1;
				live_bytes_n = live_bytes_q + BYTES_W'(req_q.byte_size);
				allocs_n     = att_pkg::sat_add(allocs_q, att_pkg::CTR_W'(1));
			end else if (found_q) begin
				live_cnt_n   = live_cnt_q - match_q;
				live_bytes_n = live_bytes_q - freed_q;
				frees_n      = att_pkg::sat_add(frees_q, att_pkg::CTR_W'(match_q));
			end else if (is_free) begin
				bad_n = att_pkg::sat_add(bad_q, att_pkg::CTR_W'(1));
			end
		end
	end

	assign match_x  = CNT_XW'(match_q);
	assign active_x = CNT_XW'(live_cnt_n);
	assign bytes_x  = BYTES_XW'(live_bytes_n);
	assign slot_x   = (IDX_W + 6)'(slot_q);

	always_comb begin
		if (null_q) begin
			rsp_n.status = att_pkg::ST_IGNORED;
		end else if (!is_free) begin
			rsp_n.status = placed_q ? att_pkg::ST_RECORDED : att_pkg::ST_POOL_FULL;
		end else begin
			rsp_n.status = found_q ? att_pkg::ST_FREED : att_pkg::ST_UNTRACKED;
		end
		rsp_n.slot         = slot_x[5:0];
		rsp_n.match_count  = (match_x > CNT_XW'(att_pkg::CNT7_MAX)) ?
			att_pkg::CNT7_MAX : match_x[6:0];
		rsp_n.active_count = (active_x > CNT_XW'(att_pkg::CNT7_MAX)) ?
			att_pkg::CNT7_MAX : active_x[6:0];
		rsp_n.active_bytes = (bytes_x > BYTES_XW'(att_pkg::BYTES38_MAX)) ?
			att_pkg::BYTES38_MAX : bytes_x[37:0];
		rsp_n.alloc_total        = allocs_n;
		rsp_n.free_total         = frees_n;
		rsp_n.invalid_free_total = bad_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_cnt_q   <= '0;
			live_bytes_q <= '0;
			allocs_q     <= '0;
			frees_q      <= '0;
			bad_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= (state_q == att_pkg::S_REPORT);
			if (state_q == att_pkg::S_REPORT) begin
				live_cnt_q   <= live_cnt_n;
				live_bytes_q <= live_bytes_n;
				allocs_q     <= allocs_n;
				frees_q      <= frees_n;
				bad_q        <= bad_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == att_pkg::S_REPORT) begin
			rsp_q <= rsp_n;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ rtl/core/allocation_tracking_table.sv @@
// Top level of the allocation tracking table: a ring of RECORDS table cells
// and the scan controller. Depends on att_pkg, att_cell and att_ctrl.
`timescale 1ns / 1ps

// Usage
// A request (command, pointer, byte_size in req) is taken at a rising edge where
// start is high and busy is low. Every request yields exactly one result on rsp,
// shown for one cycle with done high; the receiver cannot stall it, so it must
// take the result in that cycle.
// The table lives in a ring of RECORDS cells. While a request is scanned, the
// ring rotates by one cell per cycle; the controller inspects the cell at the
// head, updates it, and feeds it back in at the tail, so after a full turn
// every entry is back at its own index. An alloc takes the lowest free slot and
// a free clears every matching entry in the same pass.
// Timing: a request with a non-null pointer keeps busy high through the scan of
// every cell and then the reporting state; done is high in the first cycle with
// busy low, and a new request may be taken in that same cycle. A null pointer
// skips the scan and goes straight to the reporting state. The rate at which
// requests follow each other is set by the ring, which visits one entry per
// cycle.
// Reset clears all valid marks and the running totals at once; no clearing pass
// is needed, and start is taken right after reset is released.

module allocation_tracking_table #(
	parameter int RECORDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  att_pkg::req_t req,
	output logic          done,
	output att_pkg::rsp_t rsp
);

	// ring[i] is the entry held in cell i; cell 0 is the head.
	att_pkg::entry_t ring [RECORDS];
	att_pkg::entry_t tail;
	logic            shift;

	genvar gi;
	generate
		for (gi = 0; gi < RECORDS; gi++) begin : g_cell
			if (gi == RECORDS - 1) begin : g_last
				// The last cell is loaded with the entry the controller wrote back.
				att_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.nxt    (tail),
					.entry  (ring[gi])
				);
			end else begin : g_mid
				att_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.nxt    (ring[gi+1]),
					.entry  (ring[gi])
				);
			end
		end
	endgenerate

	// The controller sequences the scan and keeps the running totals.
	att_ctrl #(
		.RECORDS (RECORDS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.head   (ring[0]),
		.tail   (tail),
		.shift  (shift),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

@@ rtl/core/att_checker.sv @@
// Port-level checks for the allocation tracking table, bound to the top level.
// Depends on att_pkg and allocation_tracking_table.
`timescale 1ns / 1ps

module att_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input att_pkg::rsp_t rsp
);

	// An accepted request always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted request");

	// The result shows only once the block has finished its request.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// One request, one strobe: never two strobes in a row.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == att_pkg::ST_RECORDED ||
			rsp.status == att_pkg::ST_POOL_FULL ||
			rsp.status == att_pkg::ST_FREED ||
			rsp.status == att_pkg::ST_UNTRACKED ||
			rsp.status == att_pkg::ST_IGNORED))
		else $error("undefined status code");

	// Only a free that found entries reports cleared entries.
	a_match_freed: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != att_pkg::ST_FREED) |-> (rsp.match_count == '0))
		else $error("match count set on a request that cleared nothing");

endmodule

bind allocation_tracking_table att_checker u_att_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
